// ----- design/rgb_iir_pkg.sv -----
// Shared types and constants for the RGB 2-D IIR low-pass filter.
`timescale 1ns / 1ps
`default_nettype none

package rgb_iir_pkg;

   localparam int PIX_W      = 8;   // one colour sample
   localparam int CHANNELS   = 3;
   localparam int GAIN_W     = 16;  // Q0.16 gains
   localparam int GAIN_FRAC  = 16;
   localparam int IMG_W_W    = 11;  // image_width register
   localparam int IMG_H_W    = 16;  // image_height register, row counter
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [IMG_W_W-1:0]  IMG_W_RESET = 11'd1024;
   localparam logic [IMG_H_W-1:0]  IMG_H_RESET = 16'd1024;
   localparam logic [GAIN_W-1:0]   GAIN_A_RESET = 16'd655;
   localparam logic [GAIN_W-1:0]   GAIN_B_RESET = 16'd58982;
   localparam logic [GAIN_W-1:0]   GAIN_C_RESET = 16'd53084;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_INPUT_GAIN     = 3'd2,
      CSR_NEIGHBOUR_GAIN = 3'd3,
      CSR_DIAGONAL_GAIN  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] input_gain;
      logic [GAIN_W-1:0] neighbour_gain;
      logic [GAIN_W-1:0] diagonal_gain;
   } gains_type;

   // Per-pixel position flags, carried with the pixel to the filter stage
   typedef struct packed {
      logic has_left;
      logic has_up;
      logic fwd_left;   // line store read is stale: take the previous output
      logic frame_end;
   } pos_flags_type;

endpackage

`default_nettype wire

// ----- design/rgb_iir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rgb_iir_ram #(
   parameter int WIDTH = 78,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/rgb_iir_ctrl.sv -----
// Raster position counters and per-pixel edge and forwarding flags.
`timescale 1ns / 1ps
`default_nettype none

module rgb_iir_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic                                  s1_pending,
   input  wire logic [rgb_iir_pkg::IMG_W_W-1:0]       image_width,
   input  wire logic [rgb_iir_pkg::IMG_H_W-1:0]       image_height,
   output logic      [$clog2(MAX_WIDTH)-1:0]          rd_col,
   output logic      [$clog2(MAX_WIDTH)-1:0]          s1_col,
   output rgb_iir_pkg::pos_flags_type                 s1_flags
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W + 1 > rgb_iir_pkg::IMG_W_W) ? COL_W + 1
                                                             : rgb_iir_pkg::IMG_W_W;
   localparam int ROW_W = rgb_iir_pkg::IMG_H_W;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;
   rgb_iir_pkg::pos_flags_type s1_flags_ff, s1_flags_in;

   logic [CMP_W-1:0]  width_ext;
   logic [CMP_W-1:0]  width_lim;
   logic [CMP_W-1:0]  col_p1;
   logic [ROW_W:0]    row_p1;
   logic [ROW_W:0]    height_lim;
   logic              last_col;
   logic              last_row;

   always_comb begin
      width_ext = CMP_W'(image_width);
      if (width_ext == '0) begin
         width_lim = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_lim = CMP_W'(MAX_WIDTH);
      end else begin
         width_lim = width_ext;
      end
      height_lim = (image_height == '0) ? (ROW_W+1)'(1) : {1'b0, image_height};

      col_p1   = CMP_W'(col_ff) + CMP_W'(1);
      row_p1   = {1'b0, row_ff} + (ROW_W+1)'(1);
      last_col = col_p1 >= width_lim;
      last_row = row_p1 >= height_lim;

      col_in      = col_ff;
      row_in      = row_ff;
      s1_col_in   = s1_col_ff;
      s1_flags_in = s1_flags_ff;
      if (accept) begin
         col_in = last_col ? '0 : COL_W'(col_p1);
         if (last_col) begin
            row_in = last_row ? '0 : row_p1[ROW_W-1:0];
         end
         s1_col_in             = col_ff;
         s1_flags_in.has_left  = col_ff != '0;
         s1_flags_in.has_up    = row_ff != '0;
         // the pixel still waiting to be filtered writes this column after the read
         s1_flags_in.fwd_left  = s1_pending && (s1_col_ff == col_ff);
         s1_flags_in.frame_end = last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      s1_col_ff   <= s1_col_in;
      s1_flags_ff <= s1_flags_in;
   end

   assign rd_col   = col_ff;
   assign s1_col   = s1_col_ff;
   assign s1_flags = s1_flags_ff;

endmodule

`default_nettype wire

// ----- design/rgb_iir_lane.sv -----
// One colour channel of the recursive filter: weighted sum, saturation and clip.
`timescale 1ns / 1ps
`default_nettype none

module rgb_iir_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               accept,
   input  wire logic                               step,
   input  wire rgb_iir_pkg::gains_type             gains,
   input  wire rgb_iir_pkg::pos_flags_type         flags,
   input  wire logic [rgb_iir_pkg::PIX_W-1:0]      x,
   input  wire logic [FRAC_BITS+9:0]               up_ram,
   output logic      [FRAC_BITS+9:0]               y,
   output logic      [rgb_iir_pkg::PIX_W-1:0]      pix
);

   localparam int VAL_W    = FRAC_BITS + 10;            // signed Q9.F
   localparam int PROD_A_W = rgb_iir_pkg::GAIN_W + rgb_iir_pkg::PIX_W;
   localparam int ACC_W    = VAL_W + 19;
   localparam int A_PAD    = ACC_W - PROD_A_W - FRAC_BITS;
   localparam int SH_W     = ACC_W - rgb_iir_pkg::GAIN_FRAC;
   localparam int INT_W    = VAL_W - 1 - FRAC_BITS;     // integer bits of a positive value

   logic [PROD_A_W-1:0]       prod_a_ff, prod_a_in;
   logic signed [VAL_W-1:0]   left_ff, left_in;
   logic signed [VAL_W-1:0]   upleft_ff, upleft_in;

   logic signed [VAL_W-1:0]   up_raw;
   logic signed [VAL_W-1:0]   left_t;
   logic signed [VAL_W-1:0]   up_t;
   logic signed [VAL_W-1:0]   ul_t;
   logic signed [VAL_W:0]     nb_sum;
   logic signed [VAL_W+17:0]  prod_b;
   logic signed [VAL_W+16:0]  prod_c;
   logic signed [ACC_W-1:0]   acc;
   logic signed [SH_W-1:0]    shifted;
   logic                      ovf;
   logic signed [VAL_W-1:0]   y_sat;
   logic [INT_W-1:0]          int_part;

   always_comb begin
      prod_a_in = accept ? PROD_A_W'(gains.input_gain) * PROD_A_W'(x) : prod_a_ff;

      up_raw = flags.fwd_left ? left_ff : $signed(up_ram);
      left_t = flags.has_left ? left_ff : '0;
      up_t   = flags.has_up ? up_raw : '0;
      ul_t   = (flags.has_left && flags.has_up) ? upleft_ff : '0;

      nb_sum = (VAL_W+1)'(left_t) + (VAL_W+1)'(up_t);
      prod_b = $signed({1'b0, gains.neighbour_gain}) * nb_sum;
      prod_c = $signed({1'b0, gains.diagonal_gain}) * ul_t;
      acc    = $signed({{A_PAD{1'b0}}, prod_a_ff, {FRAC_BITS{1'b0}}})
             + ACC_W'(prod_b) - ACC_W'(prod_c);

      // arithmetic shift floors toward minus infinity
      shifted = acc[ACC_W-1:rgb_iir_pkg::GAIN_FRAC];
      ovf     = !(&shifted[SH_W-1:VAL_W-1]) && (|shifted[SH_W-1:VAL_W-1]);
      if (ovf) begin
         y_sat = shifted[SH_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         y_sat = shifted[VAL_W-1:0];
      end

      int_part = y_sat[VAL_W-2:FRAC_BITS];
      if (y_sat[VAL_W-1]) begin
         pix = '0;
      end else if (int_part > INT_W'(255)) begin
         pix = '1;
      end else begin
         pix = int_part[rgb_iir_pkg::PIX_W-1:0];
      end

      left_in   = step ? y_sat : left_ff;
      upleft_in = step ? up_raw : upleft_ff;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      left_ff   <= left_in;
      upleft_ff <= upleft_in;
   end

   assign y = y_sat;

endmodule

`default_nettype wire

// ----- design/rgb_2d_iir_lowpass_filter.sv -----
// Top level of the RGB 2-D IIR low-pass filter: handshakes, registers, lanes, line store.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  req      | req_tvalid/req_tready  | req_tdata: red_in, green_in, blue_in
//  rsp      | rsp_tvalid/rsp_tready  | rsp_tdata: red_out, green_out, blue_out;
//           |                        | rsp_tlast: frame_end
//  csr      | csr_valid/csr_ready    | csr_index, csr_data (always ready)
//
// One pixel per clock unless rsp stalls; path: filter stage, then output register.
// The line store read is issued on the input transfer; the left-neighbour
// feedback (one multiply-add per channel) closes in the filter cycle.
// The output register frees the filter stage, so input keeps flowing unless
// rsp is stalled with a pixel also waiting in the filter stage.
// Reset clears position counters and valid flags; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rgb_2d_iir_lowpass_filter #(
   parameter int MAX_WIDTH = 1024,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [23:0]                            req_tdata,  // red_in, green_in, blue_in
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic      [23:0]                            rsp_tdata,  // red_out, green_out, blue_out
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [rgb_iir_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rgb_iir_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int VAL_W = FRAC_BITS + 10;
   localparam int PIX_W = rgb_iir_pkg::PIX_W;
   localparam int NCH   = rgb_iir_pkg::CHANNELS;

   logic [rgb_iir_pkg::IMG_W_W-1:0] image_width_ff, image_width_in;
   logic [rgb_iir_pkg::IMG_H_W-1:0] image_height_ff, image_height_in;
   rgb_iir_pkg::gains_type          gains_ff, gains_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NCH*PIX_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    step;
   logic [COL_W-1:0]        rd_col;
   logic [COL_W-1:0]        s1_col;
   rgb_iir_pkg::pos_flags_type s1_flags;
   logic [NCH*VAL_W-1:0]    up_all;
   logic [NCH*VAL_W-1:0]    y_all;
   logic [NCH*PIX_W-1:0]    pix_all;

   // configuration registers
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      gains_in        = gains_ff;
      if (csr_valid) begin
         case (rgb_iir_pkg::csr_index_type'(csr_index))
            rgb_iir_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data[rgb_iir_pkg::IMG_W_W-1:0];
            end
            rgb_iir_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data;
            end
            rgb_iir_pkg::CSR_INPUT_GAIN: begin
               gains_in.input_gain = csr_data;
            end
            rgb_iir_pkg::CSR_NEIGHBOUR_GAIN: begin
               gains_in.neighbour_gain = csr_data;
            end
            rgb_iir_pkg::CSR_DIAGONAL_GAIN: begin
               gains_in.diagonal_gain = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // handshake and stage control
   assign step       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
      rsp_valid_in = step ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = step ? pix_all : rsp_data_ff;
      rsp_last_in  = step ? s1_flags.frame_end : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rgb_iir_pkg::IMG_W_RESET;
         image_height_ff <= rgb_iir_pkg::IMG_H_RESET;
         gains_ff        <= '{input_gain:     rgb_iir_pkg::GAIN_A_RESET,
                              neighbour_gain: rgb_iir_pkg::GAIN_B_RESET,
                              diagonal_gain:  rgb_iir_pkg::GAIN_C_RESET};
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         gains_ff        <= gains_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   rgb_iir_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .s1_pending   (s1_valid_ff),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .rd_col       (rd_col),
      .s1_col       (s1_col),
      .s1_flags     (s1_flags)
   );

   // previous row of unclipped outputs, all three channels per entry
   rgb_iir_ram #(
      .WIDTH (NCH*VAL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (s1_col),
      .wr_data (y_all),
      .rd_en   (accept),
      .rd_addr (rd_col),
      .rd_data (up_all)
   );

   for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
      rgb_iir_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .accept (accept),
         .step   (step),
         .gains  (gains_ff),
         .flags  (s1_flags),
         .x      (req_tdata[ch*PIX_W +: PIX_W]),
         .up_ram (up_all[ch*VAL_W +: VAL_W]),
         .y      (y_all[ch*VAL_W +: VAL_W]),
         .pix    (pix_all[ch*PIX_W +: PIX_W])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_hold_when_full : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step) |-> !req_tready)
      else $error("input taken while the filter stage is occupied");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel not held in the filter stage");

   a_step_outputs : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("filtered pixel not presented on rsp");

   a_fwd_needs_pending : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags.fwd_left) |-> s1_flags.has_left || (s1_col == '0))
      else $error("forwarding flag set without a preceding pixel in the column");
`endif

endmodule

`default_nettype wire

// ----- tb/rgb_2d_iir_lowpass_filter_tb.sv -----
// Self-checking bench for the RGB 2-D IIR low-pass filter: directed table, then random frames.
`timescale 1ns / 1ps
module rgb_2d_iir_lowpass_filter_tb;

   localparam int     MAX_W         = 1024;
   localparam int     FRAC          = 16;
   localparam int     VAL_W         = 10 + FRAC;
   localparam int     PIX_W         = rgb_iir_pkg::PIX_W;
   localparam int     CHANNELS      = rgb_iir_pkg::CHANNELS;
   localparam int     IMG_W_W       = rgb_iir_pkg::IMG_W_W;
   localparam int     IMG_H_W       = rgb_iir_pkg::IMG_H_W;
   localparam int     GAIN_W        = rgb_iir_pkg::GAIN_W;
   localparam int     CSR_DATA_W    = rgb_iir_pkg::CSR_DATA_W;
   localparam longint VAL_HI        = (longint'(1) <<< (VAL_W - 1)) - 1;
   localparam longint VAL_LO        = -VAL_HI - 1;
   localparam int     RANDOM_PIXELS = 1350;
   localparam int     QUIET_TAIL    = 150;
   localparam int     CYCLE_LIMIT   = 100000;

   typedef logic signed [VAL_W-1:0] fixed_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic    frame_end;
      rgb_type pix;
   } pix_result_type;

   typedef struct packed {
      bit                         is_csr;
      rgb_iir_pkg::csr_index_type idx;
      logic [CSR_DATA_W-1:0]      data;
      rgb_type                    pix;
      bit                         typed;
      pix_result_type             want;
   } stim_row_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [23:0]                rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   rgb_iir_pkg::csr_index_type csr_index  = rgb_iir_pkg::CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]      csr_data   = '0;

   rgb_2d_iir_lowpass_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Filter state as the block should hold it
   logic [IMG_W_W-1:0] cfg_width  = rgb_iir_pkg::IMG_W_RESET;
   logic [IMG_H_W-1:0] cfg_height = rgb_iir_pkg::IMG_H_RESET;
   logic [GAIN_W-1:0]  gain_a     = rgb_iir_pkg::GAIN_A_RESET;
   logic [GAIN_W-1:0]  gain_b     = rgb_iir_pkg::GAIN_B_RESET;
   logic [GAIN_W-1:0]  gain_c     = rgb_iir_pkg::GAIN_C_RESET;
   fixed_type          prev_row [MAX_W][CHANNELS];
   fixed_type          left_val [CHANNELS];
   fixed_type          diag_val [CHANNELS];
   bit                 col_written [MAX_W];
   logic [9:0]         col_pos = '0;
   logic [15:0]        row_pos = '0;

   pix_result_type pending_pixels [$];
   stim_row_type   directed_rows [$];
   string          chan_name [CHANNELS] = '{"red", "green", "blue"};
   int             error_count = 0;
   int unsigned    cycle_count = 0;
   bit             send_gaps   = 1'b0;
   bit             sink_stalls = 1'b0;
   int             stall_left  = 0;

   function automatic int eff_width(input logic [IMG_W_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_W) return MAX_W;
      return v;
   endfunction

   function automatic pix_result_type filter_pixel(input rgb_type pix);
      int unsigned    w, h, col;
      int             ch;
      bit             has_left, has_up, last_col, last_row;
      longint         left, up, diag, acc, y;
      fixed_type      up_raw;
      pix_result_type res;
      w = eff_width(cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      col = col_pos;
      has_left = (col != 0);
      has_up = (row_pos != 0);
      last_col = (col + 1 >= w);
      last_row = (row_pos + 1 >= h);
      for (ch = 0; ch < CHANNELS; ch++) begin
         up_raw = prev_row[col][ch];
         left = has_left ? longint'(left_val[ch]) : 0;
         up = has_up ? longint'(up_raw) : 0;
         diag = (has_left && has_up) ? longint'(diag_val[ch]) : 0;
         acc = longint'(gain_a) * (longint'(pix[ch*8 +: 8]) <<< FRAC)
             + longint'(gain_b) * (left + up)
             - longint'(gain_c) * diag;
         y = acc >>> rgb_iir_pkg::GAIN_FRAC;
         if (y > VAL_HI) y = VAL_HI;
         else if (y < VAL_LO) y = VAL_LO;
         diag_val[ch] = up_raw;
         left_val[ch] = y[VAL_W-1:0];
         prev_row[col][ch] = y[VAL_W-1:0];
         if (y < 0) res.pix[ch*8 +: 8] = 8'd0;
         else if (y >= (longint'(255) <<< FRAC)) res.pix[ch*8 +: 8] = 8'd255;
         else res.pix[ch*8 +: 8] = y[FRAC +: 8];
      end
      res.frame_end = last_col && last_row;
      col_written[col] = 1'b1;
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return res;
   endfunction

   function automatic rgb_type rand_pixel();
      rgb_type p;
      int      ch;
      for (ch = 0; ch < CHANNELS; ch++) begin
         case ($urandom_range(0, 9))
            0: p[ch*8 +: 8] = 8'd0;
            1: p[ch*8 +: 8] = 8'd255;
            default: p[ch*8 +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      return p;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_csr(input rgb_iir_pkg::csr_index_type idx,
                          input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      directed_rows.push_back(row);
   endtask

   task automatic add_pix(input logic [7:0] r, g, b, input bit typed,
                          input logic [7:0] er, eg, eb, input logic efe);
      stim_row_type row;
      row = '0;
      row.pix = '{blue: b, green: g, red: r};
      row.typed = typed;
      row.want = '{frame_end: efe, pix: '{blue: eb, green: eg, red: er}};
      directed_rows.push_back(row);
   endtask

   // Lower the request and wait until every pixel in flight has come out
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays high for back-to-back writes; the next pixel lowers it
   task automatic write_csr(input rgb_iir_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rgb_iir_pkg::CSR_IMAGE_WIDTH:    cfg_width  = data[IMG_W_W-1:0];
         rgb_iir_pkg::CSR_IMAGE_HEIGHT:   cfg_height = data;
         rgb_iir_pkg::CSR_INPUT_GAIN:     gain_a     = data;
         rgb_iir_pkg::CSR_NEIGHBOUR_GAIN: gain_b     = data;
         rgb_iir_pkg::CSR_DIAGONAL_GAIN:  gain_c     = data;
         default: ;
      endcase
   endtask

   task automatic send_pixel(input rgb_type pix, input bit typed, input pix_result_type want);
      pix_result_type res;
      if (csr_valid) csr_valid <= 1'b0;
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      res = filter_pixel(pix);
      pending_pixels.push_back(typed ? want : res);
   endtask

   task automatic pick_settings(input bit all);
      logic [IMG_W_W-1:0]    w;
      logic [CSR_DATA_W-1:0] data;
      int unsigned           b;
      bit                    safe;
      int                    c;
      if (all || $urandom_range(0, 1)) begin
         case ($urandom_range(0, 19))
            0: w = 0;
            1: w = 1;
            2: w = MAX_W;
            3: w = '1;
            4, 5: w = 11'($urandom_range(17, 64));
            default: w = 11'($urandom_range(2, 16));
         endcase
         // below the first row a wider row may only read columns already filled
         safe = 1'b1;
         if (row_pos != 0)
            for (c = 0; c < eff_width(w); c++)
               if (!col_written[c]) safe = 1'b0;
         if (safe) begin
            data = 16'($urandom);
            data[IMG_W_W-1:0] = w;
            write_csr(rgb_iir_pkg::CSR_IMAGE_WIDTH, data);
         end
      end
      if (all || $urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0: data = 16'd0;
            1: data = 16'd1;
            2: data = 16'hFFFF;
            default: data = 16'($urandom_range(2, 12));
         endcase
         write_csr(rgb_iir_pkg::CSR_IMAGE_HEIGHT, data);
      end
      if (all || $urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: begin
               write_csr(rgb_iir_pkg::CSR_INPUT_GAIN, rgb_iir_pkg::GAIN_A_RESET);
               write_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, rgb_iir_pkg::GAIN_B_RESET);
               write_csr(rgb_iir_pkg::CSR_DIAGONAL_GAIN, rgb_iir_pkg::GAIN_C_RESET);
            end
            1: begin
               // separable and stable: diagonal weight is the square of the neighbour one
               b = $urandom_range(0, 32767);
               write_csr(rgb_iir_pkg::CSR_INPUT_GAIN, 16'($urandom));
               write_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, 16'(b));
               write_csr(rgb_iir_pkg::CSR_DIAGONAL_GAIN, 16'((b * b) >> 16));
            end
            default: begin
               write_csr(rgb_iir_pkg::CSR_INPUT_GAIN, pick_gain());
               write_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, pick_gain());
               write_csr(rgb_iir_pkg::CSR_DIAGONAL_GAIN, pick_gain());
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      pix_result_type want;
      rgb_type        got;
      int             ch;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected transfer, data %h last %b", $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            got = rsp_tdata;
            for (ch = 0; ch < CHANNELS; ch++) begin
               if (got[ch*8 +: 8] !== want.pix[ch*8 +: 8]) begin
                  $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                           chan_name[ch], want.pix[ch*8 +: 8], got[ch*8 +: 8]);
                  error_count++;
               end
            end
            if (rsp_tlast !== want.frame_end) begin
               $display("%0t: frame_end mismatch, expected %b, actual %b", $time,
                        want.frame_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int i, j, n, random_sent;
      bit first;
      for (i = 0; i < MAX_W; i++) begin
         col_written[i] = 1'b0;
         for (j = 0; j < CHANNELS; j++) prev_row[i][j] = '0;
      end
      for (i = 0; i < CHANNELS; i++) begin
         left_val[i] = '0;
         diag_val[i] = '0;
      end

      // first pixel after reset: no neighbours, default input gain only
      add_pix(255, 0, 128, 1, 2, 0, 1, 0);
      add_csr(rgb_iir_pkg::CSR_IMAGE_HEIGHT, 16'd0);
      add_csr(rgb_iir_pkg::CSR_IMAGE_WIDTH, 16'h07FF);
      add_csr(rgb_iir_pkg::CSR_INPUT_GAIN, 16'hFFFF);
      add_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, 16'h0000);
      add_csr(rgb_iir_pkg::CSR_DIAGONAL_GAIN, 16'h0000);
      // full input gain alone: one below each nonzero sample
      add_pix(255, 1, 0, 1, 254, 0, 0, 0);
      // width shrinks mid-row: this column becomes the last, and so ends the frame
      add_csr(rgb_iir_pkg::CSR_IMAGE_WIDTH, 16'h0000);
      add_pix(128, 255, 7, 1, 127, 254, 6, 1);
      add_pix(0, 0, 0, 1, 0, 0, 0, 1);
      // 4 x 3 frame, bits above the width field set; strong feedback saturates
      add_csr(rgb_iir_pkg::CSR_IMAGE_WIDTH, 16'hF804);
      add_csr(rgb_iir_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      add_csr(rgb_iir_pkg::CSR_INPUT_GAIN, 16'h8000);
      add_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, 16'hFFFF);
      repeat (4) add_pix(255, 255, 255, 0, 0, 0, 0, 0);
      add_pix(8'h55, 8'hAA, 8'h01, 0, 0, 0, 0, 0);
      add_pix(8'hFF, 8'h00, 8'h80, 0, 0, 0, 0, 0);
      add_pix(8'h01, 8'hFE, 8'h7F, 0, 0, 0, 0, 0);
      add_pix(8'h80, 8'h40, 8'h20, 0, 0, 0, 0, 0);
      // last row with the diagonal term only: values go negative
      add_csr(rgb_iir_pkg::CSR_INPUT_GAIN, 16'h0000);
      add_csr(rgb_iir_pkg::CSR_NEIGHBOUR_GAIN, 16'h0000);
      add_csr(rgb_iir_pkg::CSR_DIAGONAL_GAIN, 16'hFFFF);
      add_pix(8'h10, 8'h20, 8'h30, 0, 0, 0, 0, 0);
      add_pix(8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0);
      add_pix(8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0);
      add_pix(8'hC3, 8'h3C, 8'h99, 0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_gaps = 1'b1;
      sink_stalls = 1'b1;
      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_csr) begin
            drain_pipeline();
            write_csr(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      random_sent = 0;
      first = 1'b1;
      while (random_sent < RANDOM_PIXELS) begin
         drain_pipeline();
         pick_settings(first);
         first = 1'b0;
         if (random_sent >= RANDOM_PIXELS - QUIET_TAIL) begin
            send_gaps = 1'b0;
            sink_stalls = 1'b0;
         end else begin
            send_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
         end
         n = $urandom_range(5, 60);
         repeat (n) begin
            send_pixel(rand_pixel(), 1'b0, '0);
            random_sent++;
         end
      end

      drain_pipeline();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
